### hdl/crbh_pkg.sv
// Shared types and constants for the closest ray / box hit block.
// Used by the controller, the datapath and the top level; depends on nothing else.
`default_nettype none
package crbh_pkg;

    // Sentinel entry parameter, 10000.0 in unsigned Q14.8.
    localparam logic [21:0] T_SENTINEL = 22'd2560000;

    // Width of a signed slab bound in Q18.8 (magnitude below 2^25).
    localparam int unsigned TW = 27;

    typedef logic signed [TW-1:0] tval_t;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_RECT_X      = 3'd0,
        CFG_RECT_Y      = 3'd1,
        CFG_RECT_WIDTH  = 3'd2,
        CFG_RECT_HEIGHT = 3'd3,
        CFG_DIR_X       = 3'd4,
        CFG_DIR_Y       = 3'd5
    } cfg_idx_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_box;
        logic       div_start;
        logic       div_store;
        logic [2:0] sel;
        logic       cast_en;
        logic [1:0] corner;
        logic       step_end;
        logic       emit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
        logic last_box;
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

### hdl/crbh_div.sv
// Iterative unsigned divider, two quotient bits per cycle.
// Stand-alone; uses no package items.
`default_nettype none
module crbh_div (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [24:0] num,
    input  wire logic [15:0] den,
    output logic             done,
    output logic [24:0]      quo,
    output logic             rem_nz
);

    logic [25:0] q_reg, q_next;
    logic [16:0] r_reg, r_next;
    logic [15:0] d_reg;
    logic [3:0]  cnt_reg, cnt_next;
    logic        done_reg, done_next;

    // Two restoring steps per cycle.
    always_comb begin
        logic [16:0] r;
        logic [25:0] q;
        r = r_reg;
        q = q_reg;
        for (int i = 0; i < 2; i++) begin
            r = {r[15:0], q[25]};
            if (r >= {1'b0, d_reg}) begin
                r = r - {1'b0, d_reg};
                q = {q[24:0], 1'b1};
            end else begin
                q = {q[24:0], 1'b0};
            end
        end
        r_next    = r;
        q_next    = q;
        cnt_next  = cnt_reg - 4'd1;
        done_next = (cnt_reg == 4'd1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else if (start) begin
            cnt_reg  <= 4'd13;
            done_reg <= 1'b0;
            q_reg    <= {1'b0, num};
            r_reg    <= '0;
            d_reg    <= den;
        end else if (cnt_reg != 4'd0) begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
            q_reg    <= q_next;
            r_reg    <= r_next;
        end else begin
            done_reg <= 1'b0;
        end
    end

    assign done   = done_reg;
    assign quo    = q_reg[24:0];
    assign rem_nz = (r_reg != '0);

endmodule
`default_nettype wire

### hdl/crbh_datapath.sv
// Datapath: configuration, box registers, slab bounds, corner test and result.
// Depends on crbh_pkg and crbh_div.
`default_nettype none
module crbh_datapath #(
    parameter int MAX_BOXES = 256
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [2:0]           cfg_index,
    input  wire logic [15:0]          cfg_data,
    input  wire logic signed [15:0]   s_box_x,
    input  wire logic signed [15:0]   s_box_y,
    input  wire logic [9:0]           s_box_w,
    input  wire logic [9:0]           s_box_h,
    input  wire logic                 s_last_box,
    input  wire crbh_pkg::cmd_t       cmd,
    output crbh_pkg::status_t         status,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic                      m_hit_found,
    output logic [21:0]               m_nearest_t,
    output logic [7:0]                m_nearest_index
);

    localparam int CW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int TW_L = crbh_pkg::TW;

    logic signed [15:0] rect_x_reg, rect_y_reg, dir_x_reg, dir_y_reg;
    logic [9:0]         rect_w_reg, rect_h_reg;
    logic signed [15:0] box_x_reg, box_y_reg;
    logic [9:0]         box_w_reg, box_h_reg;
    logic               last_reg;
    crbh_pkg::tval_t    t_reg [8];
    logic [21:0]        best_t_reg;
    logic [7:0]         best_idx_reg;
    logic [CW-1:0]      cnt_reg;
    logic               m_valid_reg;
    logic               m_hit_reg;
    logic [21:0]        m_t_reg;
    logic [7:0]         m_idx_reg;

    // Corner origins and box bounds, 18-bit signed.
    logic signed [17:0] ox0, ox1, oy0, oy1, bx0, bx1, by0, by1;
    assign ox0 = 18'(rect_x_reg);
    assign oy0 = 18'(rect_y_reg);
    assign ox1 = 18'(rect_x_reg) + 18'(signed'({1'b0, rect_w_reg, 4'b0}));
    assign oy1 = 18'(rect_y_reg) + 18'(signed'({1'b0, rect_h_reg, 4'b0}));
    assign bx0 = 18'(box_x_reg);
    assign by0 = 18'(box_y_reg);
    assign bx1 = 18'(box_x_reg) + 18'(signed'({1'b0, box_w_reg, 4'b0}));
    assign by1 = 18'(box_y_reg) + 18'(signed'({1'b0, box_h_reg, 4'b0}));

    // Divider operands for the selected slab bound.
    logic signed [17:0] org, bnd;
    logic signed [18:0] diff;
    logic [18:0]        diff_mag;
    logic signed [15:0] dsel;
    logic [15:0]        den_mag;
    logic               res_neg;
    logic               div_done;
    logic [24:0]        quo;
    logic               rem_nz;
    logic [TW_L-1:0]    qext;
    crbh_pkg::tval_t    tdiv;

    always_comb begin
        if (cmd.sel[2]) begin
            org  = cmd.sel[1] ? oy1 : oy0;
            bnd  = cmd.sel[0] ? by1 : by0;
            dsel = dir_y_reg;
        end else begin
            org  = cmd.sel[1] ? ox1 : ox0;
            bnd  = cmd.sel[0] ? bx1 : bx0;
            dsel = dir_x_reg;
        end
        diff     = 19'(bnd) - 19'(org);
        diff_mag = diff[18] ? 19'(-diff) : 19'(diff);
        den_mag  = dsel[15] ? 16'(-dsel) : 16'(dsel);
        res_neg  = diff[18] ^ dsel[15];
        qext     = TW_L'(quo) + TW_L'(rem_nz);
        tdiv     = res_neg ? crbh_pkg::tval_t'(-qext) : crbh_pkg::tval_t'(quo);
    end

    crbh_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     ({diff_mag[16:0], 8'h00}),
        .den     (den_mag),
        .done    (div_done),
        .quo     (quo),
        .rem_nz  (rem_nz)
    );

    // Corner test for the selected corner.
    crbh_pkg::tval_t xa, xb, ya, yb, xn, xf, yn, yf, tc;
    logic signed [17:0] cox, coy;
    logic dzx, dzy, inx, iny, hit;
    always_comb begin
        xa  = t_reg[{1'b0, cmd.corner[0], 1'b0}];
        xb  = t_reg[{1'b0, cmd.corner[0], 1'b1}];
        ya  = t_reg[{1'b1, cmd.corner[1], 1'b0}];
        yb  = t_reg[{1'b1, cmd.corner[1], 1'b1}];
        xn  = (xa < xb) ? xa : xb;
        xf  = (xa < xb) ? xb : xa;
        yn  = (ya < yb) ? ya : yb;
        yf  = (ya < yb) ? yb : ya;
        cox = cmd.corner[0] ? ox1 : ox0;
        coy = cmd.corner[1] ? oy1 : oy0;
        dzx = (dir_x_reg == '0);
        dzy = (dir_y_reg == '0);
        inx = (cox >= bx0) && (cox <= bx1);
        iny = (coy >= by0) && (coy <= by1);
        if (dzx)
            tc = yn;
        else if (dzy)
            tc = xn;
        else
            tc = (yn > xn) ? yn : xn;
        hit = (!dzx || inx) && (!dzy || iny) && !(dzx && dzy)
            && !(!dzx && !dzy && ((xn > yf) || (yn > xf)))
            && !tc[TW_L-1]
            && (tc < crbh_pkg::tval_t'({1'b0, best_t_reg}));
    end

    logic [31:0] cnt_ext;
    assign cnt_ext = 32'(cnt_reg);

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rect_x_reg <= '0;
            rect_y_reg <= '0;
            rect_w_reg <= 10'd16;
            rect_h_reg <= 10'd16;
            dir_x_reg  <= '0;
            dir_y_reg  <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                crbh_pkg::CFG_RECT_X:      rect_x_reg <= cfg_data;
                crbh_pkg::CFG_RECT_Y:      rect_y_reg <= cfg_data;
                crbh_pkg::CFG_RECT_WIDTH:  rect_w_reg <= cfg_data[9:0];
                crbh_pkg::CFG_RECT_HEIGHT: rect_h_reg <= cfg_data[9:0];
                crbh_pkg::CFG_DIR_X:       dir_x_reg  <= cfg_data;
                crbh_pkg::CFG_DIR_Y:       dir_y_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Box capture and slab bound storage.
    always_ff @(posedge aclk) begin
        if (cmd.load_box) begin
            box_x_reg <= s_box_x;
            box_y_reg <= s_box_y;
            box_w_reg <= s_box_w;
            box_h_reg <= s_box_h;
            last_reg  <= s_last_box;
        end
        if (cmd.div_store)
            t_reg[cmd.sel] <= tdiv;
    end

    // Running best, box counter and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_t_reg   <= crbh_pkg::T_SENTINEL;
            best_idx_reg <= '0;
            cnt_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cmd.cast_en && hit) begin
                best_t_reg   <= tc[21:0];
                best_idx_reg <= cnt_ext[7:0];
            end
            if (cmd.step_end) begin
                if (cnt_ext == 32'(MAX_BOXES - 1))
                    cnt_reg <= '0;
                else
                    cnt_reg <= cnt_reg + CW'(1);
            end
            if (cmd.emit) begin
                m_valid_reg  <= 1'b1;
                m_hit_reg    <= (best_t_reg < crbh_pkg::T_SENTINEL);
                m_t_reg      <= best_t_reg;
                m_idx_reg    <= best_idx_reg;
                best_t_reg   <= crbh_pkg::T_SENTINEL;
                best_idx_reg <= '0;
                cnt_reg      <= '0;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign status.div_done = div_done;
    assign status.last_box = last_reg;
    assign status.out_free = !m_valid_reg || m_ready;

    assign m_valid         = m_valid_reg;
    assign m_hit_found     = m_hit_reg;
    assign m_nearest_t     = m_t_reg;
    assign m_nearest_index = m_idx_reg;

endmodule
`default_nettype wire

### hdl/crbh_ctrl.sv
// Controller: sequences eight slab divisions, four corner tests and the result.
// Depends on crbh_pkg.
`default_nettype none
module crbh_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire crbh_pkg::status_t status,
    output crbh_pkg::cmd_t         cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DSTART,
        ST_DWAIT,
        ST_CAST,
        ST_END
    } state_t;

    state_t     state_reg;
    logic [2:0] sel_reg;
    logic [1:0] corner_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            sel_reg    <= '0;
            corner_reg <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        sel_reg   <= '0;
                        state_reg <= ST_DSTART;
                    end
                end
                ST_DSTART: state_reg <= ST_DWAIT;
                ST_DWAIT: begin
                    if (status.div_done) begin
                        if (sel_reg == 3'd7) begin
                            corner_reg <= '0;
                            state_reg  <= ST_CAST;
                        end else begin
                            sel_reg   <= sel_reg + 3'd1;
                            state_reg <= ST_DSTART;
                        end
                    end
                end
                ST_CAST: begin
                    corner_reg <= corner_reg + 2'd1;
                    if (corner_reg == 2'd3)
                        state_reg <= ST_END;
                end
                ST_END: begin
                    if (!status.last_box || status.out_free)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Commands decoded from the state.
    always_comb begin
        cmd           = '0;
        cmd.sel       = sel_reg;
        cmd.corner    = corner_reg;
        cmd.load_box  = (state_reg == ST_IDLE) && s_valid;
        cmd.div_start = (state_reg == ST_DSTART);
        cmd.div_store = (state_reg == ST_DWAIT) && status.div_done;
        cmd.cast_en   = (state_reg == ST_CAST);
        cmd.step_end  = (state_reg == ST_END) && !status.last_box;
        cmd.emit      = (state_reg == ST_END) && status.last_box && status.out_free;
    end

    assign s_ready = (state_reg == ST_IDLE);

endmodule
`default_nettype wire

### hdl/closest_ray_box_hit.sv
// Closest ray / box hit, top level: controller plus datapath.
// Depends on crbh_pkg, crbh_ctrl and crbh_datapath.
// Each accepted box is tested against four rays cast along (dir_x, dir_y)
// from the corners of the configured rectangle with a 2D slab test; the
// smallest non-negative entry t below 10000 (Q14.8) and its box index are
// kept, and one result leaves on the box marked last. For each box, eight
// slab bounds go one after another through a single divider that yields
// two quotient bits per cycle, then the four corners are tested in turn
// and a closing state ends the box. A finished result waits in the output
// register while the next box is worked on.
`default_nettype none
module closest_ray_box_hit #(
    parameter int MAX_BOXES = 256
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [15:0] s_box_x,
    input  wire logic signed [15:0] s_box_y,
    input  wire logic [9:0]         s_box_w,
    input  wire logic [9:0]         s_box_h,
    input  wire logic               s_last_box,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_hit_found,
    output logic [21:0]             m_nearest_t,
    output logic [7:0]              m_nearest_index
);

    crbh_pkg::cmd_t    cmd;
    crbh_pkg::status_t status;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    crbh_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    crbh_datapath #(
        .MAX_BOXES (MAX_BOXES)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_box_x         (s_box_x),
        .s_box_y         (s_box_y),
        .s_box_w         (s_box_w),
        .s_box_h         (s_box_h),
        .s_last_box      (s_last_box),
        .cmd             (cmd),
        .status          (status),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_hit_found     (m_hit_found),
        .m_nearest_t     (m_nearest_t),
        .m_nearest_index (m_nearest_index)
    );

endmodule
`default_nettype wire
